/* design/teg_pkg.sv */
// ----------------------------------------------------------------------------
// teg_pkg: shared types and constants for the tilted ellipse generator
// Fixed point types, register index codes, rotation table and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package teg_pkg;

  // Q16.16 result word and Q2.30 sine/cosine value
  typedef logic signed [31:0] q16_t;
  typedef logic signed [31:0] q30_t;

  // Configuration write data, as wide as the widest register
  typedef logic [31:0] cfg_word_t;

  // Configuration register index
  typedef enum logic [2:0] {
    CFG_SEMI_AXIS_A   = 3'd0,
    CFG_SEMI_AXIS_B   = 3'd1,
    CFG_CENTER_X      = 3'd2,
    CFG_CENTER_Z      = 3'd3,
    CFG_TILT_ANGLE    = 3'd4,
    CFG_PHASE_STEP    = 3'd5,
    CFG_OMEGA         = 3'd6,
    CFG_OMEGA_SQUARED = 3'd7
  } cfg_reg_e;

  // Rotation iteration index
  localparam int CordicIters = 30;
  typedef logic [4:0] iter_t;

  localparam q30_t        CordicGainQ30 = 32'sd652032874;
  localparam logic [32:0] TwoPiQ29      = 33'd3373259426;

  localparam logic signed [65:0] SatHi = 66'sd2147483647;
  localparam logic signed [65:0] SatLo = -66'sd2147483648;

  // atan(2^-i) in Q2.30
  function automatic q30_t atan_q30(input iter_t idx);
    q30_t v;
    unique case (idx)
      5'd0:    v = 32'sh3243F6A8;
      5'd1:    v = 32'sh1DAC6705;
      5'd2:    v = 32'sh0FADBAFC;
      5'd3:    v = 32'sh07F56EA6;
      5'd4:    v = 32'sh03FEAB76;
      5'd5:    v = 32'sh01FFD55B;
      5'd6:    v = 32'sh00FFFAAA;
      5'd7:    v = 32'sh007FFF55;
      5'd8:    v = 32'sh003FFFEA;
      5'd9:    v = 32'sh001FFFFD;
      5'd10:   v = 32'sh000FFFFF;
      5'd11:   v = 32'sh0007FFFF;
      5'd12:   v = 32'sh0003FFFF;
      5'd13:   v = 32'sh0001FFFF;
      5'd14:   v = 32'sh0000FFFF;
      5'd15:   v = 32'sh00007FFF;
      5'd16:   v = 32'sh00003FFF;
      5'd17:   v = 32'sh00001FFF;
      5'd18:   v = 32'sh00000FFF;
      5'd19:   v = 32'sh000007FF;
      5'd20:   v = 32'sh000003FF;
      5'd21:   v = 32'sh000001FF;
      5'd22:   v = 32'sh000000FF;
      5'd23:   v = 32'sh0000007F;
      5'd24:   v = 32'sh0000003F;
      5'd25:   v = 32'sh0000001F;
      5'd26:   v = 32'sh0000000F;
      5'd27:   v = 32'sh00000008;
      5'd28:   v = 32'sh00000004;
      5'd29:   v = 32'sh00000002;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to the 32-bit result range
  function automatic q16_t sat_q16(input logic signed [65:0] v);
    q16_t r;
    if (v > SatHi) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SatLo) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/tilted_ellipse_trajectory_gen_core.sv */
// ----------------------------------------------------------------------------
// tilted_ellipse_trajectory_gen_core: tilted ellipse trajectory generator
// Each input word (one control tick) yields one point of an ellipse with
// semi-axes a (x) and b (z) around (center_x, center_z), tilted about the y
// axis. The phase comes from a wrapping accumulator that advances by
// phase_step after each point; restart clears it before the point. The result
// word carries x and z of position, velocity (scaled by omega) and
// acceleration (scaled by omega_squared), all signed Q16.16 and saturated.
// Flow: a word is accepted only in idle; its result is loaded into the
// output register from ST_DONE, and the next word is taken once the block
// is back in idle; one word is finished before the next. The pace is set by
// the 30-step rotation (CORDIC) unit, run once for the trajectory phase and
// once for the tilt, and by the single 33x32 multiplier, used 18 times per
// word with a register after each product. in_stall_o stays high while a word
// is in work; a finished result waiting on out_stall_i does not block the
// input, only the hand-over of the following result. Configuration writes
// take effect at once and must be made while no word is in work.
// ----------------------------------------------------------------------------
`default_nettype none

module tilted_ellipse_trajectory_gen_core #(
  parameter int SINE_INDEX_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire teg_pkg::cfg_reg_e  cfg_idx_i,
  input  wire teg_pkg::cfg_word_t cfg_wdata_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               restart_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output teg_pkg::q16_t           pos_x_o,
  output teg_pkg::q16_t           pos_z_o,
  output teg_pkg::q16_t           vel_x_o,
  output teg_pkg::q16_t           vel_z_o,
  output teg_pkg::q16_t           acc_x_o,
  output teg_pkg::q16_t           acc_z_o
);

  import teg_pkg::*;

  localparam int TurnShift = 32 - PHASE_BITS;
  localparam int RemBits   = SINE_INDEX_BITS - 2;
  localparam int RemShift  = 32 - SINE_INDEX_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZMUL,   // angle residual times 2*pi
    ST_ZLOAD,  // seed the rotation unit
    ST_ROT,    // one rotation step per cycle
    ST_QUAD,   // fold in the quadrant
    ST_MUL,    // issue one product
    ST_ACC,    // consume the registered product
    ST_DONE    // hand the result to the output register
  } state_e;

  // Multiply sequence, one product each
  typedef enum logic [3:0] {
    MOP_PX,     // a*cos
    MOP_PZ,     // b*sin
    MOP_QX,     // -a*sin
    MOP_QZ,     // b*cos
    MOP_CA_PX,
    MOP_RPX,
    MOP_SA_PX,
    MOP_RPZ,
    MOP_CA_QX,
    MOP_RQX,
    MOP_SA_QX,
    MOP_RQZ,
    MOP_VX,
    MOP_VZ,
    MOP_AX,
    MOP_AZ
  } mop_e;

  // Configuration registers
  q16_t                  semi_a_q, semi_b_q, center_x_q, center_z_q;
  logic [15:0]           tilt_q;
  logic [PHASE_BITS-1:0] step_q;
  logic [30:0]           omega_q, omega2_q;

  // Control
  state_e                state_q;
  mop_e                  op_q;
  iter_t                 iter_q;
  logic                  pass_q;   // 0: trajectory phase, 1: tilt
  logic                  out_valid_q;
  logic [PHASE_BITS-1:0] phase_acc_q;

  // Datapath
  logic [SINE_INDEX_BITS-1:0] k_q;
  q30_t                       x_q, y_q, z_q;
  q30_t                       sp_q, cp_q, sa_q, ca_q;
  logic signed [64:0]         prod_q;
  logic signed [65:0]         acc_q;
  logic signed [32:0]         px_q, pz_q, qx_q, qz_q;
  logic signed [32:0]         rpx_q, rpz_q, rqx_q, rqz_q;
  q16_t                       vx_q, vz_q, ax_q, az_q;
  q16_t                       pos_x_q, pos_z_q, vel_x_q, vel_z_q, acc_x_q, acc_z_q;

  logic                       in_accept;
  logic                       out_load;
  logic [PHASE_BITS-1:0]      phase_cur;
  logic [31:0]                turn_p, turn_t;
  logic [SINE_INDEX_BITS-1:0] idx_sel;
  logic [1:0]                 quad;
  logic [RemBits-1:0]         rem;
  logic [29:0]                r32;
  logic signed [32:0]         mul_a;
  logic signed [31:0]         mul_b;
  logic signed [64:0]         prod_d;
  logic signed [65:0]         p_ext, p_neg, sh_src, sh_out, rot_sum, rot_out;
  logic                       neg_sel, shift16_sel, rot_add;
  q30_t                       dx, dy, atan_i;
  q30_t                       sin_v, cos_v;
  logic signed [65:0]         pos_sum_x, pos_sum_z;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  // Load the result once the output register is empty or being emptied
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Phase used by this word; restart drops the accumulated phase
  assign phase_cur = restart_i ? '0 : phase_acc_q;
  assign turn_p    = 32'(phase_cur) << TurnShift;
  assign turn_t    = {tilt_q, 16'h0000};

  // Table index: top two bits pick the quadrant, the rest the residual angle
  assign idx_sel = pass_q ? turn_t[31 -: SINE_INDEX_BITS] : k_q;
  assign quad    = idx_sel[SINE_INDEX_BITS-1 -: 2];
  assign rem     = idx_sel[RemBits-1:0];
  assign r32     = 30'(rem) << RemShift;

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_ZMUL) begin
      mul_a = $signed(TwoPiQ29);
      mul_b = $signed({2'b00, r32});
    end else if (state_q == ST_MUL) begin
      unique case (op_q)
        MOP_PX:    begin mul_a = {semi_a_q[31], semi_a_q}; mul_b = cp_q; end
        MOP_PZ:    begin mul_a = {semi_b_q[31], semi_b_q}; mul_b = sp_q; end
        MOP_QX:    begin mul_a = {semi_a_q[31], semi_a_q}; mul_b = sp_q; end
        MOP_QZ:    begin mul_a = {semi_b_q[31], semi_b_q}; mul_b = cp_q; end
        MOP_CA_PX: begin mul_a = px_q;  mul_b = ca_q; end
        MOP_RPX:   begin mul_a = pz_q;  mul_b = sa_q; end
        MOP_SA_PX: begin mul_a = px_q;  mul_b = sa_q; end
        MOP_RPZ:   begin mul_a = pz_q;  mul_b = ca_q; end
        MOP_CA_QX: begin mul_a = qx_q;  mul_b = ca_q; end
        MOP_RQX:   begin mul_a = qz_q;  mul_b = sa_q; end
        MOP_SA_QX: begin mul_a = qx_q;  mul_b = sa_q; end
        MOP_RQZ:   begin mul_a = qz_q;  mul_b = ca_q; end
        MOP_VX:    begin mul_a = rqx_q; mul_b = $signed({1'b0, omega_q}); end
        MOP_VZ:    begin mul_a = rqz_q; mul_b = $signed({1'b0, omega_q}); end
        MOP_AX:    begin mul_a = rpx_q; mul_b = $signed({1'b0, omega2_q}); end
        MOP_AZ:    begin mul_a = rpz_q; mul_b = $signed({1'b0, omega2_q}); end
        default:   begin mul_a = '0;    mul_b = '0; end
      endcase
    end
  end

  // The full product fits 65 signed bits, so the modular product is exact
  assign prod_d = {{32{mul_a[32]}}, mul_a} * {{33{mul_b[31]}}, mul_b};

  // Post-product arithmetic: floor shifts, negation and the rotation sum
  assign neg_sel     = (op_q == MOP_QX) || (op_q == MOP_AX) || (op_q == MOP_AZ);
  assign shift16_sel = (op_q == MOP_VX) || (op_q == MOP_VZ) ||
                       (op_q == MOP_AX) || (op_q == MOP_AZ);
  assign rot_add     = (op_q == MOP_RPZ) || (op_q == MOP_RQZ);

  assign p_ext   = {prod_q[64], prod_q};
  assign p_neg   = -p_ext;
  assign sh_src  = neg_sel ? p_neg : p_ext;
  assign sh_out  = shift16_sel ? (sh_src >>> 16) : (sh_src >>> 30);
  assign rot_sum = acc_q + (rot_add ? p_ext : p_neg);
  assign rot_out = rot_sum >>> 30;

  // Rotation step: shifted cross terms and the table angle
  assign dx     = y_q >>> iter_q;
  assign dy     = x_q >>> iter_q;
  assign atan_i = atan_q30(iter_q);

  // Quadrant symmetry
  always_comb begin
    case (quad)
      2'd0:    begin cos_v = x_q;  sin_v = y_q;  end
      2'd1:    begin cos_v = -y_q; sin_v = x_q;  end
      2'd2:    begin cos_v = -x_q; sin_v = -y_q; end
      default: begin cos_v = y_q;  sin_v = -x_q; end
    endcase
  end

  assign pos_sum_x = {{34{center_x_q[31]}}, center_x_q} + {{33{rpx_q[32]}}, rpx_q};
  assign pos_sum_z = {{34{center_z_q[31]}}, center_z_q} + {{33{rpz_q[32]}}, rpz_q};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      semi_a_q   <= '0;
      semi_b_q   <= '0;
      center_x_q <= '0;
      center_z_q <= '0;
      tilt_q     <= '0;
      step_q     <= '0;
      omega_q    <= '0;
      omega2_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEMI_AXIS_A:   semi_a_q   <= cfg_wdata_i;
        CFG_SEMI_AXIS_B:   semi_b_q   <= cfg_wdata_i;
        CFG_CENTER_X:      center_x_q <= cfg_wdata_i;
        CFG_CENTER_Z:      center_z_q <= cfg_wdata_i;
        CFG_TILT_ANGLE:    tilt_q     <= cfg_wdata_i[15:0];
        CFG_PHASE_STEP:    step_q     <= cfg_wdata_i[PHASE_BITS-1:0];
        CFG_OMEGA:         omega_q    <= cfg_wdata_i[30:0];
        CFG_OMEGA_SQUARED: omega2_q   <= cfg_wdata_i[30:0];
      endcase
    end
  end

  // Sequencer: state, counters, phase accumulator and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= MOP_PX;
      iter_q      <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
      phase_acc_q <= '0;
    end else begin
      // load a new result, else drop the one just taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            // advance the phase now; this word keeps the old one in k_q
            phase_acc_q <= phase_cur + step_q;
            pass_q      <= 1'b0;
            state_q     <= ST_ZMUL;
          end
        end
        ST_ZMUL: begin
          state_q <= ST_ZLOAD;
        end
        ST_ZLOAD: begin
          iter_q  <= '0;
          state_q <= ST_ROT;
        end
        ST_ROT: begin
          if (iter_q == iter_t'(CordicIters - 1)) begin
            state_q <= ST_QUAD;
          end else begin
            iter_q <= iter_q + 5'd1;
          end
        end
        ST_QUAD: begin
          if (!pass_q) begin
            pass_q  <= 1'b1;
            state_q <= ST_ZMUL;
          end else begin
            op_q    <= MOP_PX;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (op_q == MOP_AZ) begin
            state_q <= ST_DONE;
          end else begin
            op_q    <= mop_e'(op_q + 4'd1);
            state_q <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          k_q <= turn_p[31 -: SINE_INDEX_BITS];
        end
      end
      ST_ZMUL, ST_MUL: begin
        prod_q <= prod_d;
      end
      ST_ZLOAD: begin
        // residual in radians, Q2.30; the product is positive
        z_q <= {1'b0, prod_q[61:31]};
        x_q <= CordicGainQ30;
        y_q <= '0;
      end
      ST_ROT: begin
        if (!z_q[31]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_i;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_i;
        end
      end
      ST_QUAD: begin
        if (!pass_q) begin
          sp_q <= sin_v;
          cp_q <= cos_v;
        end else begin
          sa_q <= sin_v;
          ca_q <= cos_v;
        end
      end
      ST_ACC: begin
        case (op_q)
          MOP_PX:    px_q  <= sh_out[32:0];
          MOP_PZ:    pz_q  <= sh_out[32:0];
          MOP_QX:    qx_q  <= sh_out[32:0];
          MOP_QZ:    qz_q  <= sh_out[32:0];
          MOP_CA_PX: acc_q <= p_ext;
          MOP_RPX:   rpx_q <= rot_out[32:0];
          MOP_SA_PX: acc_q <= p_ext;
          MOP_RPZ:   rpz_q <= rot_out[32:0];
          MOP_CA_QX: acc_q <= p_ext;
          MOP_RQX:   rqx_q <= rot_out[32:0];
          MOP_SA_QX: acc_q <= p_ext;
          MOP_RQZ:   rqz_q <= rot_out[32:0];
          MOP_VX:    vx_q  <= sat_q16(sh_out);
          MOP_VZ:    vz_q  <= sat_q16(sh_out);
          MOP_AX:    ax_q  <= sat_q16(sh_out);
          default:   az_q  <= sat_q16(sh_out);
        endcase
      end
      ST_DONE: begin
        if (out_load) begin
          pos_x_q <= sat_q16(pos_sum_x);
          pos_z_q <= sat_q16(pos_sum_z);
          vel_x_q <= vx_q;
          vel_z_q <= vz_q;
          acc_x_q <= ax_q;
          acc_z_q <= az_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign pos_x_o = pos_x_q;
  assign pos_z_o = pos_z_q;
  assign vel_x_o = vel_x_q;
  assign vel_z_o = vel_z_q;
  assign acc_x_o = acc_x_q;
  assign acc_z_o = acc_z_q;

endmodule

`default_nettype wire

/* design/teg_checker.sv */
// ----------------------------------------------------------------------------
// teg_checker: port-level checks for the tilted ellipse generator
// Watches the channel handshakes and bound to the core below.
// ----------------------------------------------------------------------------
`default_nettype none

module teg_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire teg_pkg::q16_t pos_x_o,
  input wire teg_pkg::q16_t pos_z_o,
  input wire teg_pkg::q16_t vel_x_o,
  input wire teg_pkg::q16_t vel_z_o,
  input wire teg_pkg::q16_t acc_x_o,
  input wire teg_pkg::q16_t acc_z_o
);

  // An accepted word keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // A new result appears only at the end of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word appeared without work in progress");

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(pos_x_o) && $stable(pos_z_o) && $stable(vel_x_o) &&
       $stable(vel_z_o) && $stable(acc_x_o) && $stable(acc_z_o)))
    else $error("result word changed while stalled");

endmodule

bind tilted_ellipse_trajectory_gen_core teg_checker u_teg_checker (.*);

`default_nettype wire
